// ===== rtl/core/ppbl_pkg.sv =====
// Package for the packed pixel blend and logic-op block.
// Holds color number formats, mode codes and the per-channel helper functions.
// Depends on nothing.
package ppbl_pkg;

  localparam int CF = 15;
  localparam int CW = CF + 1;
  localparam int NW = 33 + CF;

  localparam logic [CW-1:0] C_ONE  = {1'b1, {CF{1'b0}}};
  localparam logic [CW-1:0] C_HALF = {2'b01, {(CF - 1){1'b0}}};
  localparam logic [31:0] WORD_MASK = 32'hffffffff;
  localparam logic [31:0] BYTE_MASK = 32'hff;

  typedef logic [CW-1:0] col_t;
  typedef col_t [3:0] colv_t;

  typedef enum logic [2:0] {
    CFG_SRC_LAYOUT, CFG_DST_LAYOUT, CFG_MODE, CFG_BLEND_COLOR,
    CFG_ENV_COLOR, CFG_ENV_CONST, CFG_SCALE, CFG_BIAS
  } cfg_idx_t;

  typedef enum logic [1:0] {FMT_RGBA, FMT_LUM, FMT_LUM_ALPHA, FMT_INTENSITY} fmt_t;
  typedef enum logic [1:0] {ENV_REPLACE, ENV_MODULATE, ENV_DECAL, ENV_BLEND} env_t;
  typedef enum logic [2:0] {EQ_ADD, EQ_SUB, EQ_REV_SUB, EQ_MIN, EQ_MAX} eq_t;

  typedef enum logic [3:0] {
    FAC_ZERO, FAC_ONE, FAC_SRC, FAC_INV_SRC, FAC_DST, FAC_INV_DST,
    FAC_SRC_A, FAC_INV_SRC_A, FAC_DST_A, FAC_INV_DST_A, FAC_SRC_A_SAT,
    FAC_CONST, FAC_INV_CONST, FAC_CONST_A, FAC_INV_CONST_A
  } fac_t;

  typedef enum logic [3:0] {
    LOP_CLEAR, LOP_AND, LOP_AND_REV, LOP_COPY, LOP_AND_INV, LOP_NOOP,
    LOP_XOR, LOP_OR, LOP_NOR, LOP_EQUIV, LOP_INVERT, LOP_OR_REV,
    LOP_COPY_INV, LOP_OR_INV, LOP_NAND, LOP_SET
  } lop_t;

  function automatic logic [5:0] fld_w(logic [43:0] lay, logic [1:0] ch);
    logic [5:0] w;
    w = lay[11*ch +: 6];
    return (w > 6'd32) ? 6'd32 : w;
  endfunction

  function automatic logic [4:0] fld_p(logic [43:0] lay, logic [1:0] ch);
    return lay[11*ch+6 +: 5];
  endfunction

  function automatic logic [31:0] low_mask(logic [5:0] w);
    logic [32:0] x;
    x = (33'd1 << w) - 33'd1;
    return x[31:0];
  endfunction

  function automatic logic [31:0] byte_mask(logic [1:0] b);
    logic [31:0] m;
    case (b)
      2'd0:    m = BYTE_MASK;
      2'd1:    m = {BYTE_MASK[23:0], BYTE_MASK[7:0]};
      2'd2:    m = WORD_MASK >> 8;
      default: m = WORD_MASK;
    endcase
    return m;
  endfunction

  function automatic col_t reg_color(logic [63:0] reg_v, logic [1:0] ch);
    logic [15:0] q;
    logic [CF+16:0] x;
    q = reg_v[16*ch +: 16];
    x = (({{(CF + 1){1'b0}}, q} << CF) + (CF + 17)'(16384)) >> 15;
    return (x > (CF + 17)'(C_ONE)) ? C_ONE : CW'(x);
  endfunction

  function automatic col_t cmul(col_t a, col_t b);
    logic [2*CW-1:0] p;
    p = ({{CW{1'b0}}, a} * {{CW{1'b0}}, b}) + {{CW{1'b0}}, C_HALF};
    return CW'(p >> CF);
  endfunction

  function automatic col_t factor(logic [3:0] code, logic [1:0] ch,
                                  colv_t s, colv_t d, colv_t k);
    col_t f;
    case (fac_t'(code))
      FAC_ONE:         f = C_ONE;
      FAC_SRC:         f = s[ch];
      FAC_INV_SRC:     f = C_ONE - s[ch];
      FAC_DST:         f = d[ch];
      FAC_INV_DST:     f = C_ONE - d[ch];
      FAC_SRC_A:       f = s[3];
      FAC_INV_SRC_A:   f = C_ONE - s[3];
      FAC_DST_A:       f = d[3];
      FAC_INV_DST_A:   f = C_ONE - d[3];
      FAC_SRC_A_SAT: begin
        if (ch == 2'd3) f = C_ONE;
        else f = (s[3] < C_ONE - d[3]) ? s[3] : C_ONE - d[3];
      end
      FAC_CONST:       f = k[ch];
      FAC_INV_CONST:   f = C_ONE - k[ch];
      FAC_CONST_A:     f = k[3];
      FAC_INV_CONST_A: f = C_ONE - k[3];
      default:         f = '0;
    endcase
    return f;
  endfunction

  function automatic logic [31:0] logic_op(logic [3:0] op, logic [31:0] s, logic [31:0] d);
    logic [31:0] r;
    case (lop_t'(op))
      LOP_CLEAR:    r = '0;
      LOP_AND:      r = s & d;
      LOP_AND_REV:  r = s & ~d;
      LOP_COPY:     r = s;
      LOP_AND_INV:  r = ~s & d;
      LOP_NOOP:     r = d;
      LOP_XOR:      r = s ^ d;
      LOP_OR:       r = s | d;
      LOP_NOR:      r = ~(s | d);
      LOP_EQUIV:    r = ~(s ^ d);
      LOP_INVERT:   r = ~d;
      LOP_OR_REV:   r = s | ~d;
      LOP_COPY_INV: r = ~s;
      LOP_OR_INV:   r = ~s | d;
      LOP_NAND:     r = ~(s & d);
      default:      r = WORD_MASK;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/core/packed_pixel_blend_logicop.sv =====
// Top level of the packed pixel blend and logic-op block: unpack, scale and bias,
// texture environment, blend, repack, logic op and write mask in one pipeline.
// Depends on ppbl_pkg.
//
//   Port group   Dir  Beat content
//   in_*         in   in_src_pixel, in_dst_pixel (32 bits each)
//   out_*        out  out_pixel (32 bits)
//   cfg_*        in   cfg_index (3 bits), cfg_data (64 bits), always ready
//
// One pixel per clock is accepted unless the output stalls while every stage is full.
// Sixteen of the stages are the one-bit-per-stage restoring dividers that normalize
// each unpacked field by 2^w-1; the others each unpack, multiply, add, clamp or pack.
// Each stage holds its own valid bit and loads whenever it is empty or the stage
// after it moves, so bubbles close up during an output stall.
// Reset clears the valid bits and all configuration registers.
module packed_pixel_blend_logicop
  import ppbl_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_src_pixel,
  input  logic [31:0] in_dst_pixel,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_pixel,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  localparam int NDIV = CW;
  localparam int ST_P = NDIV + 1;
  localparam int ST_S = ST_P + 1;
  localparam int ST_C = ST_S + 1;
  localparam int ST_E = ST_C + 1;
  localparam int ST_W = ST_E + 1;
  localparam int ST_R = ST_W + 1;
  localparam int ST_T = ST_R + 1;
  localparam int ST_O = ST_T + 1;
  localparam int NST  = ST_O + 1;
  localparam int AW   = CW + 18;

  logic [43:0] src_layout_r, dst_layout_r;
  logic [31:0] mode_r;
  logic [63:0] blend_color_r, env_color_r, env_const_r, scale_r, bias_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_layout_r  <= '0;
      dst_layout_r  <= '0;
      mode_r        <= '0;
      blend_color_r <= '0;
      env_color_r   <= '0;
      env_const_r   <= '0;
      scale_r       <= '0;
      bias_r        <= '0;
    end else if (cfg_valid) begin
      case (cfg_idx_t'(cfg_index))
        CFG_SRC_LAYOUT:  src_layout_r  <= cfg_data[43:0];
        CFG_DST_LAYOUT:  dst_layout_r  <= cfg_data[43:0];
        CFG_MODE:        mode_r        <= cfg_data[31:0];
        CFG_BLEND_COLOR: blend_color_r <= cfg_data;
        CFG_ENV_COLOR:   env_color_r   <= cfg_data;
        CFG_ENV_CONST:   env_const_r   <= cfg_data;
        CFG_SCALE:       scale_r       <= cfg_data;
        CFG_BIAS:        bias_r        <= cfg_data;
        default: ;
      endcase
    end
  end

  assign cfg_ready = 1'b1;

  fmt_t        fmt;
  logic        flip, blend_en;
  logic [3:0]  sfac, dfac, lop, wen;
  eq_t         eq;
  env_t        env;
  logic [31:0] sbm, dbm;

  always_comb begin
    fmt      = fmt_t'(mode_r[1:0]);
    flip     = mode_r[2];
    blend_en = mode_r[3];
    sfac     = mode_r[7:4];
    dfac     = mode_r[11:8];
    eq       = eq_t'(mode_r[14:12]);
    lop      = mode_r[18:15];
    wen      = mode_r[22:19];
    env      = env_t'(mode_r[24:23]);
    sbm      = byte_mask(mode_r[26:25]);
    dbm      = byte_mask(mode_r[28:27]);
  end

  // Lanes 0-3 are source channels R, G, B, A; lanes 4-7 are destination channels.
  logic [5:0]  lane_w [0:7];
  logic [4:0]  lane_p [0:7];
  logic [31:0] lane_m [0:7];

  always_comb begin
    for (int l = 0; l < 8; l++) begin
      lane_w[l] = fld_w((l < 4) ? src_layout_r : dst_layout_r, 2'(l));
      lane_p[l] = fld_p((l < 4) ? src_layout_r : dst_layout_r, 2'(l));
      lane_m[l] = low_mask(lane_w[l]);
    end
  end

  logic [NST-1:0] valid_r, valid_nxt, ld;

  always_comb begin
    ld[NST-1] = !valid_r[NST-1] || out_ready;
    for (int k = NST - 2; k >= 0; k--) ld[k] = !valid_r[k] || ld[k+1];
    valid_nxt = {valid_r[NST-2:0], in_valid};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      for (int k = 0; k < NST; k++) if (ld[k]) valid_r[k] <= valid_nxt[k];
    end
  end

  assign in_ready  = ld[0];
  assign out_valid = valid_r[NST-1];

  logic [31:0] dw_r [0:NST-1];
  logic [31:0] dw_nxt;

  assign dw_nxt = in_dst_pixel & dbm;

  always_ff @(posedge clk) begin
    if (ld[0]) dw_r[0] <= dw_nxt;
    for (int k = 1; k < NST; k++) if (ld[k]) dw_r[k] <= dw_r[k-1];
  end

  logic [NW-1:0] rem_r [0:NDIV][0:7];
  logic [NW-1:0] rem0_nxt [0:7];
  logic [CW-1:0] q_r [1:NDIV][0:7];

  always_comb begin
    logic [31:0] word, t;
    for (int l = 0; l < 8; l++) begin
      word = (l < 4) ? (in_src_pixel & sbm) : dw_nxt;
      t = (word >> lane_p[l]) & lane_m[l];
      if (l < 4 && flip && lane_w[l] != 6'd0) t = t ^ (32'd1 << (lane_w[l] - 6'd1));
      rem0_nxt[l] = {1'b0, t, {CF{1'b0}}} + NW'(lane_m[l] >> 1);
    end
  end

  always_ff @(posedge clk) begin
    if (ld[0]) begin
      for (int l = 0; l < 8; l++) rem_r[0][l] <= rem0_nxt[l];
    end
  end

  for (genvar j = 0; j < NDIV; j++) begin : g_div
    logic [NW-1:0] rem_nxt [0:7];
    logic [CW-1:0] q_nxt [0:7];

    always_comb begin
      logic [NW-1:0] dvs;
      logic [CW-1:0] qin;
      for (int l = 0; l < 8; l++) begin
        dvs = NW'(lane_m[l]) << (CW - 1 - j);
        if (j == 0) qin = '0;
        else qin = q_r[(j == 0) ? 1 : j][l];
        if (rem_r[j][l] >= dvs) begin
          rem_nxt[l] = rem_r[j][l] - dvs;
          q_nxt[l]   = qin | (CW'(1) << (CW - 1 - j));
        end else begin
          rem_nxt[l] = rem_r[j][l];
          q_nxt[l]   = qin;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (ld[j+1]) begin
        for (int l = 0; l < 8; l++) begin
          rem_r[j+1][l] <= rem_nxt[l];
          q_r[j+1][l]   <= q_nxt[l];
        end
      end
    end
  end

  logic signed [CW+16:0] prod_r [0:3];
  logic signed [CW+16:0] prod_nxt [0:3];
  colv_t d_p_r, d_p_nxt;

  always_comb begin
    colv_t s_ex;
    for (int c = 0; c < 4; c++) begin
      if (lane_w[c] == 6'd0) s_ex[c] = (c == 3) ? C_ONE : '0;
      else s_ex[c] = q_r[NDIV][c];
      if (lane_w[c+4] == 6'd0) d_p_nxt[c] = (c == 3) ? C_ONE : '0;
      else d_p_nxt[c] = q_r[NDIV][c+4];
    end
    if (fmt == FMT_INTENSITY) s_ex[3] = s_ex[0];
    if (fmt != FMT_RGBA) begin
      s_ex[1] = s_ex[0];
      s_ex[2] = s_ex[0];
    end
    for (int c = 0; c < 4; c++) begin
      prod_nxt[c] = $signed({1'b0, s_ex[c]}) * $signed(scale_r[16*c +: 16]);
    end
  end

  always_ff @(posedge clk) begin
    if (ld[ST_P]) begin
      prod_r <= prod_nxt;
      d_p_r  <= d_p_nxt;
    end
  end

  colv_t s_s_r, s_s_nxt, d_s_r;

  always_comb begin
    logic signed [AW-1:0] acc, bias_ext, rnd;
    for (int c = 0; c < 4; c++) begin
      bias_ext = AW'($signed(bias_r[16*c +: 16]));
      acc = AW'(prod_r[c]) + (bias_ext <<< CF);
      rnd = (acc + AW'(2048)) >>> 12;
      if (acc <= 0) s_s_nxt[c] = '0;
      else if (rnd > AW'(C_ONE)) s_s_nxt[c] = C_ONE;
      else s_s_nxt[c] = CW'(rnd);
    end
  end

  always_ff @(posedge clk) begin
    if (ld[ST_S]) begin
      s_s_r <= s_s_nxt;
      d_s_r <= d_p_r;
    end
  end

  colv_t c1_r, c2_r, s_c_r, d_c_r, c1_nxt, c2_nxt;

  always_comb begin
    col_t a1, a2, b2, e, k;
    for (int c = 0; c < 4; c++) begin
      e = reg_color(env_color_r, 2'(c));
      k = reg_color(env_const_r, 2'(c));
      if (env == ENV_DECAL) begin
        a1 = C_ONE - s_s_r[3];
        a2 = s_s_r[3];
        b2 = s_s_r[c];
      end else begin
        a1 = (env == ENV_BLEND && c < 3) ? C_ONE - s_s_r[c] : s_s_r[c];
        a2 = s_s_r[c];
        b2 = k;
      end
      c1_nxt[c] = cmul(a1, e);
      c2_nxt[c] = cmul(a2, b2);
    end
  end

  always_ff @(posedge clk) begin
    if (ld[ST_C]) begin
      c1_r  <= c1_nxt;
      c2_r  <= c2_nxt;
      s_c_r <= s_s_r;
      d_c_r <= d_s_r;
    end
  end

  colv_t s_e_r, s_e_nxt, d_e_r;

  always_comb begin
    logic [CW:0] sum;
    for (int c = 0; c < 4; c++) begin
      sum = {1'b0, c1_r[c]} + {1'b0, c2_r[c]};
      case (env)
        ENV_MODULATE: s_e_nxt[c] = c1_r[c];
        ENV_DECAL: begin
          if (c < 3) s_e_nxt[c] = (sum > {1'b0, C_ONE}) ? C_ONE : sum[CW-1:0];
          else s_e_nxt[c] = s_c_r[c];
        end
        ENV_BLEND: begin
          if (c < 3) s_e_nxt[c] = (sum > {1'b0, C_ONE}) ? C_ONE : sum[CW-1:0];
          else s_e_nxt[c] = c1_r[c];
        end
        default: s_e_nxt[c] = s_c_r[c];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (ld[ST_E]) begin
      s_e_r <= s_e_nxt;
      d_e_r <= d_c_r;
    end
  end

  colv_t ws_r, wd_r, s_w_r, d_w_r, ws_nxt, wd_nxt;

  always_comb begin
    colv_t bc;
    for (int c = 0; c < 4; c++) bc[c] = reg_color(blend_color_r, 2'(c));
    for (int c = 0; c < 4; c++) begin
      ws_nxt[c] = cmul(s_e_r[c], factor(sfac, 2'(c), s_e_r, d_e_r, bc));
      wd_nxt[c] = cmul(d_e_r[c], factor(dfac, 2'(c), s_e_r, d_e_r, bc));
    end
  end

  always_ff @(posedge clk) begin
    if (ld[ST_W]) begin
      ws_r  <= ws_nxt;
      wd_r  <= wd_nxt;
      s_w_r <= s_e_r;
      d_w_r <= d_e_r;
    end
  end

  colv_t r_r, r_nxt;

  always_comb begin
    logic [CW:0] sum;
    for (int c = 0; c < 4; c++) begin
      sum = {1'b0, ws_r[c]} + {1'b0, wd_r[c]};
      if (!blend_en) begin
        r_nxt[c] = s_w_r[c];
      end else begin
        case (eq)
          EQ_SUB:     r_nxt[c] = (ws_r[c] > wd_r[c]) ? ws_r[c] - wd_r[c] : '0;
          EQ_REV_SUB: r_nxt[c] = (wd_r[c] > ws_r[c]) ? wd_r[c] - ws_r[c] : '0;
          EQ_MIN:     r_nxt[c] = (s_w_r[c] < d_w_r[c]) ? s_w_r[c] : d_w_r[c];
          EQ_MAX:     r_nxt[c] = (s_w_r[c] > d_w_r[c]) ? s_w_r[c] : d_w_r[c];
          default:    r_nxt[c] = (sum > {1'b0, C_ONE}) ? C_ONE : sum[CW-1:0];
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ld[ST_R]) r_r <= r_nxt;
  end

  logic [31:0] t_r [0:3];
  logic [31:0] t_nxt [0:3];

  always_comb begin
    logic [CW+31:0] p;
    for (int c = 0; c < 4; c++) begin
      p = ({32'd0, r_r[c]} * {{CW{1'b0}}, lane_m[c+4]}) + (CW + 32)'(C_HALF);
      t_nxt[c] = 32'(p >> CF) & lane_m[c+4];
    end
  end

  always_ff @(posedge clk) begin
    if (ld[ST_T]) t_r <= t_nxt;
  end

  logic [31:0] out_pixel_r, out_pixel_nxt;

  always_comb begin
    logic [31:0] packed_w, wmask, res;
    packed_w = '0;
    wmask    = '0;
    for (int c = 0; c < 4; c++) begin
      if (lane_w[c+4] != 6'd0) begin
        packed_w = packed_w | (t_r[c] << lane_p[c+4]);
        if (wen[c]) wmask = wmask | (lane_m[c+4] << lane_p[c+4]);
      end
    end
    res = logic_op(lop, packed_w, dw_r[ST_T]);
    out_pixel_nxt = ((res & wmask) | (dw_r[ST_T] & ~wmask)) & dbm;
  end

  always_ff @(posedge clk) begin
    if (ld[ST_O]) out_pixel_r <= out_pixel_nxt;
  end

  assign out_pixel = out_pixel_r;

  a_ready_when_out_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !valid_r[NST-1] |-> in_ready)
    else $error("Input not ready while the output stage is empty.");

  a_accept_fills_first: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> valid_r[0])
    else $error("Accepted beat did not enter the first stage.");

  a_stall_holds_stage: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r[NST-1] && !out_ready && valid_r[NST-2]) |=> valid_r[NST-2])
    else $error("Stage before the output lost its beat during a stall.");

  a_clamp_range: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r[ST_S] |-> (s_s_r[0] <= C_ONE && s_s_r[1] <= C_ONE &&
                       s_s_r[2] <= C_ONE && s_s_r[3] <= C_ONE))
    else $error("Scaled color exceeds one.");

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for packed_pixel_blend_logicop: directed table plus random pixels,
// checked beat by beat against an in-bench pixel predictor with random idling on both sides.
// Depends on ppbl_pkg and the packed_pixel_blend_logicop RTL.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import ppbl_pkg::*;

  localparam int FB = 15;
  localparam longint ONE = 64'd1 << FB;
  localparam longint HALF = ONE >> 1;
  localparam int LATENCY = 25;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [31:0] in_src_pixel = '0;
  logic [31:0] in_dst_pixel = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [31:0] out_pixel;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [63:0] cfg_data = '0;

  packed_pixel_blend_logicop u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_src_pixel(in_src_pixel), .in_dst_pixel(in_dst_pixel),
    .out_valid(out_valid), .out_ready(out_ready), .out_pixel(out_pixel),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  logic [63:0] shadow_reg [8];
  logic [31:0] pending_pixels [$];
  int errors = 0;
  int pixels_checked = 0;
  int configs_written = 0;
  bit stim_done = 1'b0;

  typedef struct {
    logic [31:0] src;
    logic [31:0] dst;
    bit known;
    logic [31:0] want;
  } row_t;

  function automatic longint unsigned cap_one(longint unsigned a);
    return (a > ONE) ? ONE : a;
  endfunction

  function automatic longint unsigned qmul(longint unsigned a, longint unsigned b);
    return (a * b + HALF) >> FB;
  endfunction

  function automatic longint unsigned reg_q(logic [63:0] r, int ch);
    longint unsigned q;
    q = r[16*ch +: 16];
    return cap_one((q * ONE + 16384) >> 15);
  endfunction

  function automatic int lay_w(logic [63:0] lay, int ch);
    int w;
    w = lay[11*ch +: 6];
    return (w > 32) ? 32 : w;
  endfunction

  function automatic void unpack_word(longint unsigned word, logic [63:0] lay, bit flip,
                                      output longint unsigned col [4]);
    int w;
    longint unsigned m, t;
    for (int ch = 0; ch < 4; ch++) begin
      w = lay_w(lay, ch);
      if (w == 0) begin
        col[ch] = (ch == 3) ? ONE : 0;
      end else begin
        m = (64'd1 << w) - 1;
        t = (word >> lay[11*ch+6 +: 5]) & m;
        if (flip) t ^= 64'd1 << (w - 1);
        col[ch] = ((t << FB) + (m >> 1)) / m;
      end
    end
  endfunction

  function automatic longint unsigned blend_factor(fac_t code, int ch, longint unsigned s [4],
                                                   longint unsigned d [4], longint unsigned k [4]);
    case (code)
      FAC_ONE:         return ONE;
      FAC_SRC:         return s[ch];
      FAC_INV_SRC:     return ONE - s[ch];
      FAC_DST:         return d[ch];
      FAC_INV_DST:     return ONE - d[ch];
      FAC_SRC_A:       return s[3];
      FAC_INV_SRC_A:   return ONE - s[3];
      FAC_DST_A:       return d[3];
      FAC_INV_DST_A:   return ONE - d[3];
      FAC_SRC_A_SAT:   return (ch == 3) ? ONE : ((s[3] < ONE - d[3]) ? s[3] : ONE - d[3]);
      FAC_CONST:       return k[ch];
      FAC_INV_CONST:   return ONE - k[ch];
      FAC_CONST_A:     return k[3];
      FAC_INV_CONST_A: return ONE - k[3];
      default:         return 0;
    endcase
  endfunction

  function automatic logic [31:0] apply_lop(lop_t op, logic [31:0] s, logic [31:0] d);
    case (op)
      LOP_CLEAR:    return '0;
      LOP_AND:      return s & d;
      LOP_AND_REV:  return s & ~d;
      LOP_COPY:     return s;
      LOP_AND_INV:  return ~s & d;
      LOP_NOOP:     return d;
      LOP_XOR:      return s ^ d;
      LOP_OR:       return s | d;
      LOP_NOR:      return ~(s | d);
      LOP_EQUIV:    return ~(s ^ d);
      LOP_INVERT:   return ~d;
      LOP_OR_REV:   return s | ~d;
      LOP_COPY_INV: return ~s;
      LOP_OR_INV:   return ~s | d;
      LOP_NAND:     return ~(s & d);
      default:      return 32'hffffffff;
    endcase
  endfunction

  function automatic logic [31:0] blend_pixel(logic [31:0] src_px, logic [31:0] dst_px);
    logic [31:0] mw, res;
    fmt_t fmt;
    env_t env;
    eq_t eqn;
    longint unsigned sbm, dbm, sw, dw, m, t, packed_w, wmask, ws, wd;
    longint unsigned s [4], d [4], r [4], e [4], k [4], bc [4];
    longint sc, bi, acc;
    int w;
    mw = shadow_reg[CFG_MODE][31:0];
    fmt = fmt_t'(mw[1:0]);
    env = env_t'(mw[24:23]);
    eqn = eq_t'(mw[14:12]);
    sbm = (64'd1 << (8 * (mw[26:25] + 1))) - 1;
    dbm = (64'd1 << (8 * (mw[28:27] + 1))) - 1;
    sw = src_px & sbm;
    dw = dst_px & dbm;
    unpack_word(sw, shadow_reg[CFG_SRC_LAYOUT], mw[2], s);
    if (fmt == FMT_INTENSITY) s[3] = s[0];
    if (fmt != FMT_RGBA) begin
      s[1] = s[0];
      s[2] = s[0];
    end
    for (int ch = 0; ch < 4; ch++) begin
      sc = $signed(shadow_reg[CFG_SCALE][16*ch +: 16]);
      bi = $signed(shadow_reg[CFG_BIAS][16*ch +: 16]);
      acc = longint'(s[ch]) * sc + bi * longint'(ONE);
      s[ch] = (acc <= 0) ? 0 : cap_one((longint'(acc) + 2048) >>> 12);
      e[ch] = reg_q(shadow_reg[CFG_ENV_COLOR], ch);
      k[ch] = reg_q(shadow_reg[CFG_ENV_CONST], ch);
      bc[ch] = reg_q(shadow_reg[CFG_BLEND_COLOR], ch);
    end
    case (env)
      ENV_MODULATE: for (int ch = 0; ch < 4; ch++) s[ch] = qmul(s[ch], e[ch]);
      ENV_DECAL: for (int ch = 0; ch < 3; ch++)
        s[ch] = cap_one(qmul(ONE - s[3], e[ch]) + qmul(s[3], s[ch]));
      ENV_BLEND: begin
        for (int ch = 0; ch < 3; ch++)
          s[ch] = cap_one(qmul(ONE - s[ch], e[ch]) + qmul(s[ch], k[ch]));
        s[3] = qmul(s[3], e[3]);
      end
      default: ;
    endcase
    unpack_word(dw, shadow_reg[CFG_DST_LAYOUT], 1'b0, d);
    for (int ch = 0; ch < 4; ch++) begin
      if (mw[3]) begin
        ws = qmul(s[ch], blend_factor(fac_t'(mw[7:4]), ch, s, d, bc));
        wd = qmul(d[ch], blend_factor(fac_t'(mw[11:8]), ch, s, d, bc));
        case (eqn)
          EQ_SUB:     r[ch] = (ws > wd) ? ws - wd : 0;
          EQ_REV_SUB: r[ch] = (wd > ws) ? wd - ws : 0;
          EQ_MIN:     r[ch] = (s[ch] < d[ch]) ? s[ch] : d[ch];
          EQ_MAX:     r[ch] = (s[ch] > d[ch]) ? s[ch] : d[ch];
          default:    r[ch] = cap_one(ws + wd);
        endcase
      end else begin
        r[ch] = s[ch];
      end
    end
    packed_w = 0;
    wmask = 0;
    for (int ch = 0; ch < 4; ch++) begin
      w = lay_w(shadow_reg[CFG_DST_LAYOUT], ch);
      if (w != 0) begin
        m = (64'd1 << w) - 1;
        t = (r[ch] * m + HALF) >> FB;
        packed_w |= (t & m) << shadow_reg[CFG_DST_LAYOUT][11*ch+6 +: 5];
        if (mw[19+ch]) wmask |= m << shadow_reg[CFG_DST_LAYOUT][11*ch+6 +: 5];
      end
    end
    res = apply_lop(lop_t'(mw[18:15]), packed_w[31:0], dw[31:0]);
    return ((res & wmask[31:0]) | (dw[31:0] & ~wmask[31:0])) & dbm[31:0];
  endfunction

  task automatic idle_gap();
    int n;
    n = $urandom_range(0, 99);
    if (n < 55) n = 0;
    else if (n < 93) n = $urandom_range(1, 3);
    else n = $urandom_range(8, 30);
    repeat (n) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [63:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    shadow_reg[idx] = value;
    configs_written++;
    @(posedge clk);
  endtask

  task automatic send_pixel(logic [31:0] src_px, logic [31:0] dst_px);
    in_valid <= 1'b1;
    in_src_pixel <= src_px;
    in_dst_pixel <= dst_px;
    pending_pixels.push_back(blend_pixel(src_px, dst_px));
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  function automatic logic [10:0] rand_field();
    int w;
    w = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 12);
    return {5'($urandom_range(0, 31)), 6'(w)};
  endfunction

  function automatic logic [43:0] rand_layout();
    logic [43:0] lay;
    case ($urandom_range(0, 3))
      0: lay = {11'(24 << 6 | 8), 11'(16 << 6 | 8), 11'(8 << 6 | 8), 11'(8)};
      1: lay = {11'(15 << 6 | 1), 11'(10 << 6 | 5), 11'(5 << 6 | 5), 11'(5)};
      2: lay = 44'({$urandom(), $urandom()});
      default: lay = {rand_field(), rand_field(), rand_field(), rand_field()};
    endcase
    return lay;
  endfunction

  function automatic logic [63:0] rand_colors();
    logic [63:0] v;
    v = {$urandom(), $urandom()};
    for (int ch = 0; ch < 4; ch++)
      if ($urandom_range(0, 3) == 0) v[16*ch +: 16] = $urandom_range(0, 1) ? 16'h8000 : 16'h0;
    return v;
  endfunction

  function automatic logic [63:0] rand_scale();
    logic [63:0] v;
    for (int ch = 0; ch < 4; ch++)
      case ($urandom_range(0, 3))
        0, 1: v[16*ch +: 16] = 16'h1000;
        2: v[16*ch +: 16] = 16'($signed($urandom_range(0, 12288)) - 16'sd2048);
        default: v[16*ch +: 16] = 16'($urandom());
      endcase
    return v;
  endfunction

  function automatic logic [63:0] rand_bias();
    logic [63:0] v;
    for (int ch = 0; ch < 4; ch++)
      case ($urandom_range(0, 3))
        0, 1: v[16*ch +: 16] = 16'h0;
        2: v[16*ch +: 16] = 16'($signed($urandom_range(0, 2048)) - 16'sd1024);
        default: v[16*ch +: 16] = 16'($urandom());
      endcase
    return v;
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_pixels.size() == 0) begin
        $error("unexpected out_pixel beat: actual %h", out_pixel);
        errors++;
      end else begin
        if (out_pixel !== pending_pixels[0]) begin
          $error("out_pixel mismatch: expected %h actual %h", pending_pixels[0], out_pixel);
          errors++;
        end
        void'(pending_pixels.pop_front());
        pixels_checked++;
      end
    end
  end

  initial begin
    @(posedge clk);
    while (1) begin
      if (stim_done || $urandom_range(0, 3) != 0) begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end else begin
        out_ready <= 1'b0;
        idle_gap();
        @(posedge clk);
      end
    end
  end

  initial begin
    #40ms;
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    row_t rows [$];
    logic [31:0] mw;
    int done_items;
    for (int i = 0; i < 8; i++) shadow_reg[i] = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset config: all widths zero, so mask is empty and only the low destination byte survives.
    rows.push_back('{32'hffffffff, 32'hffffffff, 1'b1, 32'h000000ff});
    rows.push_back('{32'h00000000, 32'h12345678, 1'b1, 32'h00000078});
    foreach (rows[i]) begin
      send_pixel(rows[i].src, rows[i].dst);
      pending_pixels[$] = rows[i].known ? rows[i].want : pending_pixels[$];
      if ($urandom_range(0, 2) == 0) begin
        in_valid <= 1'b0;
        @(posedge clk);
        idle_gap();
      end
    end
    drain();

    // RGBA8888 copy with all channels enabled and full 32-bit words.
    write_reg(CFG_SRC_LAYOUT,
              64'({11'(24 << 6 | 8), 11'(16 << 6 | 8), 11'(8 << 6 | 8), 11'(8)}));
    write_reg(CFG_DST_LAYOUT,
              64'({11'(24 << 6 | 8), 11'(16 << 6 | 8), 11'(8 << 6 | 8), 11'(8)}));
    write_reg(CFG_SCALE, {4{16'h1000}});
    mw = '0;
    mw[18:15] = LOP_COPY;
    mw[22:19] = 4'hf;
    mw[26:25] = 2'd3;
    mw[28:27] = 2'd3;
    write_reg(CFG_MODE, 64'(mw));
    rows.delete();
    rows.push_back('{32'hffffffff, 32'h00000000, 1'b1, 32'hffffffff});
    rows.push_back('{32'h00000000, 32'hffffffff, 1'b1, 32'h00000000});
    rows.push_back('{32'h80402010, 32'h5a5aa5a5, 1'b1, 32'h80402010});
    foreach (rows[i]) begin
      send_pixel(rows[i].src, rows[i].dst);
      pending_pixels[$] = rows[i].want;
    end
    drain();

    // Every logic op and every env mode on one fixed pixel, with blending on for the odd ops.
    write_reg(CFG_BLEND_COLOR, 64'h8000_4000_2000_7fff);
    write_reg(CFG_ENV_COLOR, 64'h6000_8000_0001_ffff);
    write_reg(CFG_ENV_CONST, 64'h1234_8000_0000_4000);
    write_reg(CFG_BIAS, 64'h0000_0100_ff00_0000);
    for (int op = 0; op < 16; op++) begin
      mw[18:15] = 4'(op);
      mw[3] = op[0];
      mw[14:12] = 3'(op % 8);
      mw[24:23] = 2'(op % 4);
      mw[7:4] = 4'(op);
      mw[11:8] = 4'(15 - op);
      mw[1:0] = 2'(op / 4);
      mw[2] = op[1];
      write_reg(CFG_MODE, 64'(mw));
      send_pixel(32'hc3a5_0ff0, 32'h3c5a_f00f);
      drain();
    end

    // Random phases: fresh settings, then a burst of pixels.
    done_items = 0;
    while (done_items < 1150) begin
      write_reg(CFG_SRC_LAYOUT, 64'(rand_layout()));
      write_reg(CFG_DST_LAYOUT, 64'(rand_layout()));
      write_reg(CFG_MODE, 64'($urandom()));
      write_reg(CFG_BLEND_COLOR, rand_colors());
      write_reg(CFG_ENV_COLOR, rand_colors());
      write_reg(CFG_ENV_CONST, rand_colors());
      write_reg(CFG_SCALE, rand_scale());
      write_reg(CFG_BIAS, rand_bias());
      repeat ($urandom_range(20, 60)) begin
        case ($urandom_range(0, 5))
          0: send_pixel(32'hffffffff, $urandom());
          1: send_pixel($urandom(), 32'h0);
          default: send_pixel($urandom(), $urandom());
        endcase
        done_items++;
        if ($urandom_range(0, 3) == 0) begin
          in_valid <= 1'b0;
          @(posedge clk);
          idle_gap();
        end
      end
      drain();
    end

    stim_done = 1'b1;
    $display("Checked %0d output pixels over %0d register writes.", pixels_checked,
             configs_written);
    $display("Covered all logic ops, equations, env modes and random layouts.");
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
